@@ hw/rtl/pcs_pkg.sv @@
// Shared constants, types and state codes for the plane constraint solver.
package pcs_pkg;

  localparam int MaxPlanes = 8;
  localparam int PlaneIdxW = (MaxPlanes > 1) ? $clog2(MaxPlanes) : 1;
  localparam int CountW    = $clog2(MaxPlanes + 1);
  localparam int WordW     = 32;
  localparam int NormW     = 14;
  localparam int FracBits  = 12;
  localparam int SlopW     = 13;
  localparam int SweepW    = 6;
  localparam int KindW     = 2;
  localparam int InIdxW    = 3;
  localparam int InCountW  = 4;
  localparam int LimitW    = 31;
  localparam int CfgW      = 13;
  localparam int CfgIdxW   = 1;
  localparam int StepW     = 2;

  localparam logic [KindW-1:0] KindLoad  = 2'd0;
  localparam logic [KindW-1:0] KindSolve = 2'd1;
  localparam logic [KindW-1:0] KindClip  = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgSlop       = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgSweepLimit = 1'd1;

  localparam logic [SlopW-1:0]  SlopReset       = 13'd20;
  localparam logic [SweepW-1:0] SweepLimitReset = 6'd20;

  localparam logic [StepW-1:0] StepLast = 2'd3;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic signed [NormW-1:0] norm_t;

  typedef struct packed {
    logic                 en;
    logic [PlaneIdxW-1:0] idx;
    norm_t                nx;
    norm_t                ny;
    norm_t                nz;
    word_t                off;
    word_t                limit;
    logic                 clip;
  } load_t;

  typedef struct packed {
    norm_t nx;
    norm_t ny;
    norm_t nz;
    word_t off;
    word_t limit;
    word_t push;
    logic  clip;
  } plane_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_PLANE,
    ST_DOT,
    ST_SEP,
    ST_ACC,
    ST_CLAMP,
    ST_CHANGE,
    ST_ALONG,
    ST_CNEG,
    ST_SWEEP_END,
    ST_DONE
  } state_e;

endpackage

@@ hw/rtl/pcs_mac.sv @@
// Shared Q12 multiplier: word times normal component, floor shift, registered result.
module pcs_mac (
  input  logic          clk_i,
  input  pcs_pkg::word_t a_i,
  input  pcs_pkg::norm_t n_i,
  output pcs_pkg::word_t q_o
);
  import pcs_pkg::*;

  logic signed [WordW+NormW-1:0] prod;
  word_t                         q_q;

  // The arithmetic shift of the full product gives the exact floor.
  assign prod = a_i * n_i;

  always_ff @(posedge clk_i) begin
    q_q <= prod[WordW+FracBits-1:FracBits];
  end

  assign q_o = q_q;

endmodule

@@ hw/rtl/pcs_plane_store.sv @@
// Plane entry registers: normals, offsets, limits, clip flags and accumulated pushes.
module pcs_plane_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pcs_pkg::load_t                load_i,
  input  logic                          clr_en_i,
  input  logic [pcs_pkg::CountW-1:0]    clr_count_i,
  input  logic                          push_we_i,
  input  pcs_pkg::word_t                push_data_i,
  input  logic [pcs_pkg::PlaneIdxW-1:0] rd_idx_i,
  output pcs_pkg::plane_t               plane_o
);
  import pcs_pkg::*;

  norm_t                nx_q    [MaxPlanes];
  norm_t                ny_q    [MaxPlanes];
  norm_t                nz_q    [MaxPlanes];
  word_t                off_q   [MaxPlanes];
  word_t                limit_q [MaxPlanes];
  word_t                push_q  [MaxPlanes];
  logic [MaxPlanes-1:0] clip_q;

  always_ff @(posedge clk_i) begin
    if (load_i.en) begin
      nx_q[load_i.idx]    <= load_i.nx;
      ny_q[load_i.idx]    <= load_i.ny;
      nz_q[load_i.idx]    <= load_i.nz;
      off_q[load_i.idx]   <= load_i.off;
      limit_q[load_i.idx] <= load_i.limit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= '0;
      for (int i = 0; i < MaxPlanes; i++) begin
        push_q[i] <= '0;
      end
    end else begin
      if (load_i.en) begin
        clip_q[load_i.idx] <= load_i.clip;
        push_q[load_i.idx] <= '0;
      end
      // A solve starts with every push it will use set back to zero.
      if (clr_en_i) begin
        for (int i = 0; i < MaxPlanes; i++) begin
          if (CountW'(i) < clr_count_i) begin
            push_q[i] <= '0;
          end
        end
      end
      if (push_we_i) begin
        push_q[rd_idx_i] <= push_data_i;
      end
    end
  end

  always_comb begin
    plane_o.nx    = nx_q[rd_idx_i];
    plane_o.ny    = ny_q[rd_idx_i];
    plane_o.nz    = nz_q[rd_idx_i];
    plane_o.off   = off_q[rd_idx_i];
    plane_o.limit = limit_q[rd_idx_i];
    plane_o.push  = push_q[rd_idx_i];
    plane_o.clip  = clip_q[rd_idx_i];
  end

endmodule

@@ hw/rtl/plane_constraint_solver.sv @@
// Top level: sequencer and datapath of the iterative plane constraint solver.
//
//   channel   direction  handshake               contents
//   in        to block   in_valid_i/in_stall_o   kind, plane fields, vector, plane count
//   out       from block out_valid_o/out_stall_i out_x/y/z, sweeps_used
//   cfg       to block   cfg_we_i                linear_slop (0), sweep_limit (1)
//
// A load request completes in its accept cycle and returns nothing.
// A solve runs sweeps over the n planes until the total change falls below the slop or
// the sweep limit stops it; a clip visits each of the n planes, takes a dot product for
// each clipping plane with a nonzero push and pushes where that dot product is negative.
// Every product goes through the one shared multiplier, one component per cycle.
// Reset restores the register defaults and clears clip flags and pushes at once.
// A finished result waits in the output register; the block returns to idle as
// soon as that register is free, so the next request can enter while it is held.
module plane_constraint_solver (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pcs_pkg::KindW-1:0]         kind_i,
  input  logic [pcs_pkg::InIdxW-1:0]        plane_index_i,
  input  logic signed [pcs_pkg::NormW-1:0]  normal_x_i,
  input  logic signed [pcs_pkg::NormW-1:0]  normal_y_i,
  input  logic signed [pcs_pkg::NormW-1:0]  normal_z_i,
  input  logic signed [pcs_pkg::WordW-1:0]  plane_offset_i,
  input  logic [pcs_pkg::LimitW-1:0]        limit_of_push_i,
  input  logic                              clip_enable_i,
  input  logic signed [pcs_pkg::WordW-1:0]  vec_x_i,
  input  logic signed [pcs_pkg::WordW-1:0]  vec_y_i,
  input  logic signed [pcs_pkg::WordW-1:0]  vec_z_i,
  input  logic [pcs_pkg::InCountW-1:0]      plane_count_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [pcs_pkg::WordW-1:0]  out_x_o,
  output logic signed [pcs_pkg::WordW-1:0]  out_y_o,
  output logic signed [pcs_pkg::WordW-1:0]  out_z_o,
  output logic [pcs_pkg::SweepW-1:0]        sweeps_used_o,
  input  logic                              cfg_we_i,
  input  logic [pcs_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [pcs_pkg::CfgW-1:0]          cfg_data_i
);
  import pcs_pkg::*;

  state_e state_q, state_d;

  logic [SlopW-1:0]  slop_q;
  logic [SweepW-1:0] sweep_limit_q;

  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] p_q, p_d;
  logic [StepW-1:0]  k_q, k_d;
  logic              is_clip_q, is_clip_d;
  logic [SweepW-1:0] sweeps_q, sweeps_d;
  word_t vx_q, vx_d, vy_q, vy_d, vz_q, vz_d;
  word_t dot_q, dot_d, sep_q, sep_d, acc_q, acc_d, old_q, old_d;
  word_t change_q, change_d, abs_q, abs_d, total_q, total_d;

  logic  out_valid_q;
  logic  out_load;
  word_t out_x_q, out_y_q, out_z_q;
  logic [SweepW-1:0] out_sweeps_q;

  logic   accept;
  logic   out_free;
  load_t  load;
  logic   clr_en;
  logic   push_we;
  word_t  push_data;
  plane_t plane;
  word_t  mac_a, mac_q;
  norm_t  mac_n;
  word_t  slop_w;
  word_t  fwd, bwd;
  logic   skip_plane;
  logic [CountW-1:0] count_sat;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign slop_w     = {{(WordW-SlopW){1'b0}}, slop_q};
  assign fwd        = acc_q - old_q;
  assign bwd        = old_q - acc_q;
  assign skip_plane = is_clip_q && ((plane.push == '0) || !plane.clip);
  assign count_sat  = (int'(plane_count_i) > MaxPlanes) ? CountW'(MaxPlanes)
                                                        : CountW'(plane_count_i);

  always_comb begin
    load.en    = accept && (kind_i == KindLoad) && (int'(plane_index_i) < MaxPlanes);
    load.idx   = PlaneIdxW'(plane_index_i);
    load.nx    = normal_x_i;
    load.ny    = normal_y_i;
    load.nz    = normal_z_i;
    load.off   = plane_offset_i;
    load.limit = {{(WordW-LimitW){1'b0}}, limit_of_push_i};
    load.clip  = clip_enable_i;
  end

  assign clr_en = accept && (kind_i == KindSolve);

  pcs_plane_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .clr_en_i    (clr_en),
    .clr_count_i (count_sat),
    .push_we_i   (push_we),
    .push_data_i (push_data),
    .rd_idx_i    (p_q[PlaneIdxW-1:0]),
    .plane_o     (plane)
  );

  // Operand select for the shared multiplier: one component per step.
  always_comb begin
    case (k_q)
      2'd0: begin
        mac_a = vx_q;
        mac_n = plane.nx;
      end
      2'd1: begin
        mac_a = vy_q;
        mac_n = plane.ny;
      end
      default: begin
        mac_a = vz_q;
        mac_n = plane.nz;
      end
    endcase
    if (state_q == ST_ALONG) begin
      mac_a = change_q;
    end
  end

  pcs_mac u_mac (
    .clk_i (clk_i),
    .a_i   (mac_a),
    .n_i   (mac_n),
    .q_o   (mac_q)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            KindSolve: state_d = ST_SWEEP;
            KindClip:  state_d = ST_PLANE;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: state_d = (sweeps_q < sweep_limit_q) ? ST_PLANE : ST_DONE;
      ST_PLANE: begin
        if (p_q == count_q) begin
          state_d = is_clip_q ? ST_DONE : ST_SWEEP_END;
        end else if (!skip_plane) begin
          state_d = ST_DOT;
        end
      end
      ST_DOT: begin
        if (k_q == StepLast) begin
          state_d = is_clip_q ? ST_CNEG : ST_SEP;
        end
      end
      ST_SEP:    state_d = ST_ACC;
      ST_ACC:    state_d = ST_CLAMP;
      ST_CLAMP:  state_d = ST_CHANGE;
      ST_CHANGE: state_d = ST_ALONG;
      ST_ALONG: begin
        if (k_q == StepLast) begin
          state_d = ST_PLANE;
        end
      end
      ST_CNEG:      state_d = dot_q[WordW-1] ? ST_ALONG : ST_PLANE;
      ST_SWEEP_END: state_d = ($signed(total_q) < $signed(slop_w)) ? ST_DONE : ST_SWEEP;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates for each state.
  always_comb begin
    count_d   = count_q;
    p_d       = p_q;
    k_d       = k_q;
    is_clip_d = is_clip_q;
    sweeps_d  = sweeps_q;
    vx_d      = vx_q;
    vy_d      = vy_q;
    vz_d      = vz_q;
    dot_d     = dot_q;
    sep_d     = sep_q;
    acc_d     = acc_q;
    old_d     = old_q;
    change_d  = change_q;
    abs_d     = abs_q;
    total_d   = total_q;
    push_we   = 1'b0;
    push_data = acc_q;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          count_d   = count_sat;
          p_d       = '0;
          k_d       = '0;
          is_clip_d = (kind_i == KindClip);
          sweeps_d  = '0;
          vx_d      = vec_x_i;
          vy_d      = vec_y_i;
          vz_d      = vec_z_i;
        end
      end
      ST_SWEEP: begin
        total_d = '0;
        p_d     = '0;
      end
      ST_PLANE: begin
        k_d = '0;
        if ((p_q != count_q) && skip_plane) begin
          p_d = p_q + CountW'(1);
        end
      end
      ST_DOT: begin
        k_d = k_q + 2'd1;
        if (k_q == 2'd1) begin
          dot_d = mac_q;
        end else if (k_q != 2'd0) begin
          dot_d = dot_q + mac_q;
        end
      end
      ST_SEP: sep_d = dot_q - plane.off + slop_w;
      ST_ACC: begin
        acc_d = plane.push - sep_q;
        old_d = plane.push;
      end
      ST_CLAMP: begin
        if (acc_q[WordW-1]) begin
          push_data = '0;
        end else if ($signed(plane.limit) < $signed(acc_q)) begin
          push_data = plane.limit;
        end else begin
          push_data = acc_q;
        end
        push_we = 1'b1;
        acc_d   = push_data;
      end
      ST_CHANGE: begin
        change_d = fwd;
        abs_d    = fwd[WordW-1] ? bwd : fwd;
        k_d      = '0;
      end
      ST_ALONG: begin
        k_d = k_q + 2'd1;
        case (k_q)
          2'd0: begin
            if (!is_clip_q) begin
              total_d = total_q + abs_q;
            end
          end
          2'd1: vx_d = vx_q + mac_q;
          2'd2: vy_d = vy_q + mac_q;
          default: begin
            vz_d = vz_q + mac_q;
            p_d  = p_q + CountW'(1);
          end
        endcase
      end
      ST_CNEG: begin
        change_d = '0 - dot_q;
        k_d      = '0;
        if (!dot_q[WordW-1]) begin
          p_d = p_q + CountW'(1);
        end
      end
      ST_SWEEP_END: begin
        if (!($signed(total_q) < $signed(slop_w))) begin
          sweeps_d = sweeps_q + SweepW'(1);
        end
      end
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      slop_q        <= SlopReset;
      sweep_limit_q <= SweepLimitReset;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgSlop:       slop_q        <= cfg_data_i[SlopW-1:0];
          CfgSweepLimit: sweep_limit_q <= cfg_data_i[SweepW-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    count_q   <= count_d;
    p_q       <= p_d;
    k_q       <= k_d;
    is_clip_q <= is_clip_d;
    sweeps_q  <= sweeps_d;
    vx_q      <= vx_d;
    vy_q      <= vy_d;
    vz_q      <= vz_d;
    dot_q     <= dot_d;
    sep_q     <= sep_d;
    acc_q     <= acc_d;
    old_q     <= old_d;
    change_q  <= change_d;
    abs_q     <= abs_d;
    total_q   <= total_d;
    if (out_load) begin
      out_x_q      <= vx_q;
      out_y_q      <= vy_q;
      out_z_q      <= vz_q;
      out_sweeps_q <= sweeps_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_z_o       = out_z_q;
  assign sweeps_used_o = out_sweeps_q;

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the completion step");

  a_plane_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (p_q <= count_q))
    else $error("plane counter ran past the plane count");

  a_dot_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DOT) && (k_q == StepLast) |=> (state_q != ST_DOT))
    else $error("dot product did not end after the last component");

  a_sweeps_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (sweeps_q <= sweep_limit_q))
    else $error("sweep count exceeded the sweep limit");

endmodule
